// ===== rtl/rac_pkg.sv =====
// ----------------------------------------------------------------------------
// rac_pkg
// Shared types and constants of the row address cache: operation codes,
// sequencer states and the fixed widths of the item fields.
// ----------------------------------------------------------------------------
package rac_pkg;

	localparam int OP_W          = 2;
	localparam int ROW_ADDRESS_W = 18;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP     = 2'd0,
		OP_INSERT     = 2'd1,
		OP_INVALIDATE = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_BASE,
		ST_SCAN,
		ST_DECIDE,
		ST_UPDATE,
		ST_INVAL,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/rac_req_if.sv =====
// ----------------------------------------------------------------------------
// rac_req_if
// Request channel of the row address cache: one operation per item.
// ----------------------------------------------------------------------------
interface rac_req_if import rac_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic [ROW_ADDRESS_W-1:0] row_address;

	modport source (output valid, operation, row_address, input ready);
	modport sink   (input valid, operation, row_address, output ready);

endinterface

// ===== rtl/rac_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rac_rsp_if
// Response channel of the row address cache: one result item per request.
// ----------------------------------------------------------------------------
interface rac_rsp_if import rac_pkg::*; ();

	logic valid;
	logic ready;
	logic hit;
	logic inserted;
	logic evicted;

	modport source (output valid, hit, inserted, evicted, input ready);
	modport sink   (input valid, hit, inserted, evicted, output ready);

endinterface

// ===== rtl/row_address_cache_lru_top.sv =====
// ----------------------------------------------------------------------------
// row_address_cache_lru_top
// Set-associative cache of DRAM row addresses with age-based LRU replacement.
// ----------------------------------------------------------------------------
// Each request item is one lookup, insert or invalidate and gives exactly one
// response item. Tags, ages and valid bits live in single-port-read memories
// of SETS*WAYS entries; a small sequencer walks the ways of a set one entry
// per cycle through a single tag and age compare. A lookup hit makes a second
// pass over the ways that writes the aged values back. When SETS is not a
// power of two the set index for lookups and inserts comes from a reciprocal
// multiply and one correction step.
// After reset a clearing pass over the SETS*WAYS entries resets the valid
// memory before the first request is taken. A finished response waits in
// an output register, so the next request is accepted while it is still
// pending.
// ----------------------------------------------------------------------------
module row_address_cache_lru_top import rac_pkg::*; #(
	parameter int WAYS      = 4,
	parameter int SETS      = 32,
	parameter int ROW_WIDTH = 18
) (
	input  logic       clk,
	input  logic       arst_n,
	rac_req_if.sink    req,
	rac_rsp_if.source  rsp
);

	localparam int ENTRIES = SETS * WAYS;
	localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int WAY_W   = $clog2(WAYS + 1);
	localparam int WIDX_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int AGE_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
	localparam bit IS_POW2 = ((SETS & (SETS - 1)) == 0);

	localparam logic [AGE_W-1:0]     AGE_MAX    = AGE_W'(WAYS - 1);
	localparam logic [ENTRY_W-1:0]   ENTRY_LAST = ENTRY_W'(ENTRIES - 1);
	localparam logic [WAY_W-1:0]     WAY_END    = WAY_W'(WAYS);
	localparam logic [ROW_WIDTH-1:0] RECIP      = ROW_WIDTH'((64'd1 << ROW_WIDTH) / 64'(SETS));

	// entry memories
	logic [ROW_WIDTH-1:0] tag_mem [ENTRIES];
	logic [AGE_W-1:0]     age_mem [ENTRIES];
	logic                 vld_mem [ENTRIES];

	state_t state_q, state_d;

	logic [OP_W-1:0]        op_q;
	logic [ROW_WIDTH-1:0]   row_q;
	logic [1:0]             mod_step_q;
	logic [2*ROW_WIDTH-1:0] prod_q;
	logic [ROW_WIDTH-1:0]   quot_scaled;
	logic [ROW_WIDTH-1:0]   rem_est_q;
	logic [SET_W-1:0]       rem_q;
	logic [SET_W-1:0]       rem_next;
	logic [SET_W-1:0]       set_idx;
	logic [ENTRY_W-1:0]     base_q;
	logic [ENTRY_W-1:0]     clr_cnt_q;
	logic [ENTRY_W-1:0]     ptr_q;
	logic [WAY_W-1:0]       way_cnt_q;
	logic [WIDX_W-1:0]      way_idx;

	logic                 pend_s1;
	logic [WIDX_W-1:0]    way_s1;
	logic [ROW_WIDTH-1:0] rd_tag_s1;
	logic [AGE_W-1:0]     rd_age_s1;
	logic                 rd_vld_s1;

	logic                 way_valid_q [WAYS];
	logic [AGE_W-1:0]     way_age_q   [WAYS];
	logic                 hit_found_q;
	logic [WIDX_W-1:0]    hit_way_q;
	logic                 inv_found_q;
	logic [WIDX_W-1:0]    inv_way_q;
	logic [WIDX_W-1:0]    min_way_q;
	logic [AGE_W-1:0]     min_age_q;
	logic [WIDX_W-1:0]    victim;

	logic                 rsp_valid_q;
	logic                 hit_q;
	logic                 inserted_q;
	logic                 evicted_q;

	logic                 rd_en;
	logic [ENTRY_W-1:0]   rd_addr;
	logic [ENTRY_W-1:0]   wr_addr;
	logic                 tag_we;
	logic                 age_we;
	logic                 vld_we;
	logic                 vld_wd;
	logic [AGE_W-1:0]     age_wd;
	logic [AGE_W-1:0]     cur_age;
	logic                 rsp_load;
	logic                 res_hit;
	logic                 res_inserted;
	logic                 res_evicted;

	assign way_idx     = way_cnt_q[WIDX_W-1:0];
	assign cur_age     = way_age_q[way_idx];
	assign victim      = inv_found_q ? inv_way_q : min_way_q;
	// quotient estimate is exact or one short, so one subtract corrects it
	assign quot_scaled = prod_q[2*ROW_WIDTH-1:ROW_WIDTH] * ROW_WIDTH'(SETS);
	assign rem_next    = (32'(rem_est_q) >= 32'(SETS)) ? SET_W'(rem_est_q - ROW_WIDTH'(SETS))
	                                                  : SET_W'(rem_est_q);
	assign set_idx     = IS_POW2 ? SET_W'(row_q & ROW_WIDTH'(SETS - 1)) : rem_q;

	assign res_hit      = (op_t'(op_q) == OP_LOOKUP) && hit_found_q;
	assign res_inserted = (op_t'(op_q) == OP_INSERT) && !hit_found_q;
	assign res_evicted  = res_inserted && !inv_found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = base_q + ENTRY_W'(way_idx);
		wr_addr   = base_q + ENTRY_W'(way_idx);
		tag_we    = 1'b0;
		age_we    = 1'b0;
		vld_we    = 1'b0;
		vld_wd    = 1'b0;
		age_wd    = AGE_MAX;
		rsp_load  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				vld_we  = 1'b1;
				wr_addr = clr_cnt_q;
				if (clr_cnt_q == ENTRY_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (op_t'(req.operation)) inside
						OP_LOOKUP, OP_INSERT: state_d = IS_POW2 ? ST_BASE : ST_MOD;
						OP_INVALIDATE:        state_d = ST_INVAL;
						default:              state_d = ST_DONE;
					endcase
				end
			end
			ST_MOD: begin
				if (mod_step_q == 2'd2) begin
					state_d = ST_BASE;
				end
			end
			ST_BASE: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (way_cnt_q < WAY_END) begin
					rd_en = 1'b1;
				end else begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_DONE;
				if (res_hit) begin
					state_d = ST_UPDATE;
				end
				if (res_inserted) begin
					wr_addr = base_q + ENTRY_W'(victim);
					tag_we  = 1'b1;
					age_we  = 1'b1;
					vld_we  = 1'b1;
					vld_wd  = 1'b1;
				end
			end
			ST_UPDATE: begin
				if (way_cnt_q < WAY_END) begin
					age_we = way_valid_q[way_idx];
					if (way_idx == hit_way_q) begin
						age_wd = AGE_MAX;
					end else if (cur_age != '0) begin
						age_wd = cur_age - AGE_W'(1);
					end else begin
						age_wd = cur_age;
					end
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_INVAL: begin
				vld_we  = 1'b1;
				wr_addr = ptr_q;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[wr_addr] <= row_q;
		end
		if (age_we) begin
			age_mem[wr_addr] <= age_wd;
		end
		if (vld_we) begin
			vld_mem[wr_addr] <= vld_wd;
		end
		if (rd_en) begin
			rd_tag_s1 <= tag_mem[rd_addr];
			rd_age_s1 <= age_mem[rd_addr];
			rd_vld_s1 <= vld_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			ptr_q       <= '0;
			way_cnt_q   <= '0;
			pend_s1     <= 1'b0;
			hit_found_q <= 1'b0;
			inv_found_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + ENTRY_W'(1);
			end
			if (state_q == ST_INVAL) begin
				ptr_q <= (ptr_q == ENTRY_LAST) ? '0 : ptr_q + ENTRY_W'(1);
			end
			if (state_q == ST_BASE || state_q == ST_DECIDE) begin
				way_cnt_q <= '0;
			end else if ((state_q == ST_SCAN || state_q == ST_UPDATE) && way_cnt_q < WAY_END) begin
				way_cnt_q <= way_cnt_q + WAY_W'(1);
			end
			if (state_q == ST_BASE) begin
				hit_found_q <= 1'b0;
				inv_found_q <= 1'b0;
			end else if (pend_s1) begin
				if (rd_vld_s1 && rd_tag_s1 == row_q && !hit_found_q) begin
					hit_found_q <= 1'b1;
				end
				if (!rd_vld_s1 && !inv_found_q) begin
					inv_found_q <= 1'b1;
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			op_q       <= req.operation;
			row_q      <= ROW_WIDTH'(req.row_address);
			mod_step_q <= '0;
		end
		// set index: multiply, scale and subtract, correct
		if (state_q == ST_MOD) begin
			mod_step_q <= mod_step_q + 2'd1;
			prod_q     <= {{ROW_WIDTH{1'b0}}, row_q} * {{ROW_WIDTH{1'b0}}, RECIP};
			rem_est_q  <= row_q - quot_scaled;
			rem_q      <= rem_next;
		end
		if (state_q == ST_BASE) begin
			base_q <= ENTRY_W'(32'(set_idx) * WAYS);
		end
		if (pend_s1) begin
			way_valid_q[way_s1] <= rd_vld_s1;
			way_age_q[way_s1]   <= rd_age_s1;
			if (rd_vld_s1 && rd_tag_s1 == row_q && !hit_found_q) begin
				hit_way_q <= way_s1;
			end
			if (!rd_vld_s1 && !inv_found_q) begin
				inv_way_q <= way_s1;
			end
			if (way_s1 == '0 || rd_age_s1 < min_age_q) begin
				min_way_q <= way_s1;
				min_age_q <= rd_age_s1;
			end
		end
		if (rd_en) begin
			way_s1 <= way_idx;
		end
		if (rsp_load) begin
			hit_q      <= res_hit;
			inserted_q <= res_inserted;
			evicted_q  <= res_evicted;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.hit      = hit_q;
	assign rsp.inserted = inserted_q;
	assign rsp.evicted  = evicted_q;

	// checks
	a_evict_needs_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.evicted) |-> rsp.inserted)
		else $error("evicted without inserted");

	a_hit_excl_insert: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.inserted))
		else $error("hit and inserted in one item");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("ready right after accept");

	a_ptr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INVAL) |=>
		((ptr_q == ENTRY_W'($past(ptr_q) + ENTRY_W'(1))) || (ptr_q == '0)))
		else $error("invalidate pointer did not advance");

endmodule
